[src/psct_pkg.sv]
// Shared types and constants for the plane set cull test block
package psct_pkg;

  // Number of plane cells in the chain
  localparam int MAX_PLANES = 6;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int COEF_W    = 16;
  localparam int PLANE_W   = 4 * COEF_W;
  localparam int AXES      = 3;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int D_SHIFT   = 14;
  localparam int CNT_W     = 3;
  localparam int INDEX_W   = 3;
  localparam int PIDX_W    = 3;

  // Cycles from an accepted item to its done strobe
  localparam int LATENCY   = 2 * MAX_PLANES + 1;

  // Register indexes on the write port
  localparam logic [INDEX_W-1:0] REG_PLANE_COUNT = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PLANE_FIRST = 3'd1;
  localparam logic [INDEX_W-1:0] REG_PLANE_LAST  = 3'd6;

  // Item kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_IN  = 2'd0,
    VERDICT_OUT = 2'd1,
    VERDICT_MID = 2'd2
  } verdict_t;

  // Item traveling down the cell chain, with the flags gathered so far
  typedef struct packed {
    logic                          vld;
    logic                          kind;
    logic                          box_valid;
    logic [AXES-1:0][COORD_W-1:0]  lo;
    logic [AXES-1:0][COORD_W-1:0]  hi;
    logic                          all_out;
    logic                          some_out;
  } item_t;

endpackage

[src/plane_set_cull_test_top.sv]
// Top level of the plane set cull test: register file, cell chain, result stage
//
// Classifies a point or an axis-aligned box against up to six planes.
// Input channel: the item fields are sampled at a rising edge with start high
// and busy low. Busy stays low, so a new item can be taken in every cycle.
// Result channel: done is high for exactly one cycle with verdict valid
// (0 inside, 1 outside, 2 intermediate). The receiver cannot stall; results
// leave in the order the items came in.
// Throughput: one item per cycle. The pipeline is the chain of six plane
// cells, each a multiply stage and a sum-and-compare stage, plus the result
// register.
// Configuration: write enable, index and data. Index 0 sets the plane count
// from the low three data bits (7 becomes 6), indexes 1 to 6 hold the plane
// words, other indexes are ignored. Write only while no item is in flight.
// Reset: synchronous, clears the plane count, the plane words and the chain,
// so no done strobe comes out of items taken before reset.
module plane_set_cull_test_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic                               box_valid,
  input  logic signed [psct_pkg::COORD_W-1:0] x_low,
  input  logic signed [psct_pkg::COORD_W-1:0] y_low,
  input  logic signed [psct_pkg::COORD_W-1:0] z_low,
  input  logic signed [psct_pkg::COORD_W-1:0] x_high,
  input  logic signed [psct_pkg::COORD_W-1:0] y_high,
  input  logic signed [psct_pkg::COORD_W-1:0] z_high,
  input  logic                               wr_en,
  input  logic [psct_pkg::INDEX_W-1:0]        wr_index,
  input  logic [psct_pkg::PLANE_W-1:0]        wr_data,
  output logic                               done,
  output logic [1:0]                         verdict
);
  import psct_pkg::*;

  logic [CNT_W-1:0]    plane_count;
  logic [PLANE_W-1:0]  planes [MAX_PLANES];
  logic [CNT_W-1:0]    count_wr;
  logic [PIDX_W-1:0]   plane_sel;
  item_t               chain [MAX_PLANES+1];
  item_t               last;
  verdict_t            verdict_next;
  verdict_t            verdict_q;

  assign busy = 1'b0;

  // Saturate the plane count and locate the plane word
  assign count_wr  = (wr_data[CNT_W-1:0] > CNT_W'(MAX_PLANES)) ?
                     CNT_W'(MAX_PLANES) : wr_data[CNT_W-1:0];
  assign plane_sel = PIDX_W'(wr_index - REG_PLANE_FIRST);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
      for (int i = 0; i < MAX_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_PLANE_COUNT) begin
        plane_count <= count_wr;
      end else if (wr_index <= REG_PLANE_LAST) begin
        planes[plane_sel] <= wr_data;
      end
    end
  end

  // Form the entering item; a point uses its position for both bounds
  always_comb begin
    chain[0].vld       = start & ~busy;
    chain[0].kind      = kind;
    chain[0].box_valid = box_valid;
    chain[0].lo        = {z_low, y_low, x_low};
    if (kind == KIND_POINT) begin
      chain[0].hi = {z_low, y_low, x_low};
    end else begin
      chain[0].hi = {z_high, y_high, x_high};
    end
    chain[0].all_out  = 1'b0;
    chain[0].some_out = 1'b0;
  end

  // Chain of plane cells
  for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
    psct_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .enable   (plane_count > CNT_W'(g)),
      .plane    (planes[g]),
      .item_in  (chain[g]),
      .item_out (chain[g+1])
    );
  end

  assign last = chain[MAX_PLANES];

  // Decide the verdict from the gathered flags
  always_comb begin
    if (last.kind == KIND_BOX && !last.box_valid) begin
      verdict_next = VERDICT_MID;
    end else if (last.all_out) begin
      verdict_next = VERDICT_OUT;
    end else if (last.some_out) begin
      verdict_next = VERDICT_MID;
    end else begin
      verdict_next = VERDICT_IN;
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    verdict_q <= verdict_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.vld;
    end
  end

  assign verdict = verdict_q;

endmodule

[src/psct_cell.sv]
// One plane cell: tests the passing item against one stored plane
module psct_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic [psct_pkg::PLANE_W-1:0]  plane,
  input  psct_pkg::item_t               item_in,
  output psct_pkg::item_t               item_out
);
  import psct_pkg::*;

  item_t                     item_a;
  item_t                     item_b;
  logic signed [PROD_W-1:0]  prod_lo [AXES];
  logic signed [PROD_W-1:0]  prod_hi [AXES];
  logic signed [PROD_W-1:0]  prod_lo_q [AXES];
  logic signed [PROD_W-1:0]  prod_hi_q [AXES];
  logic signed [SUM_W-1:0]   min_sum;
  logic signed [SUM_W-1:0]   max_sum;
  logic signed [SUM_W-1:0]   offset;

  // Take the item from the neighbor
  always_ff @(posedge clk) begin
    item_a <= item_in;
    if (rst) begin
      item_a.vld <= 1'b0;
    end
  end

  // Multiply each normal component by both box bounds
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      prod_lo[k] = $signed(plane[k*COEF_W +: COEF_W]) * $signed(item_a.lo[k]);
      prod_hi[k] = $signed(plane[k*COEF_W +: COEF_W]) * $signed(item_a.hi[k]);
    end
  end

  // Hold the products with the item
  always_ff @(posedge clk) begin
    item_b <= item_a;
    prod_lo_q <= prod_lo;
    prod_hi_q <= prod_hi;
    if (rst) begin
      item_b.vld <= 1'b0;
    end
  end

  // Sum the smallest and largest corner distances
  always_comb begin
    offset  = SUM_W'($signed(plane[AXES*COEF_W +: COEF_W])) <<< D_SHIFT;
    min_sum = offset;
    max_sum = offset;
    for (int k = 0; k < AXES; k++) begin
      if (prod_lo_q[k] < prod_hi_q[k]) begin
        min_sum = min_sum + SUM_W'(prod_lo_q[k]);
        max_sum = max_sum + SUM_W'(prod_hi_q[k]);
      end else begin
        min_sum = min_sum + SUM_W'(prod_hi_q[k]);
        max_sum = max_sum + SUM_W'(prod_lo_q[k]);
      end
    end
  end

  // Merge this plane's outcome into the item flags
  always_comb begin
    item_out = item_b;
    if (enable) begin
      item_out.all_out  = item_b.all_out  | (max_sum < 0);
      item_out.some_out = item_b.some_out | (min_sum < 0);
    end
  end

endmodule

[src/psct_checker.sv]
// Port-level checks for the plane set cull test and their binding
module psct_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               kind,
  input logic                               box_valid,
  input logic                               done,
  input logic [1:0]                         verdict
);
  import psct_pkg::*;

  // Every accepted item yields a strobe after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item gave no result");

  // No strobe without an item taken earlier
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted item");

  // Only defined verdict codes appear
  a_code_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (verdict == VERDICT_IN || verdict == VERDICT_OUT ||
              verdict == VERDICT_MID))
    else $error("undefined verdict code");

  // A point is never intermediate
  a_point_binary: assert property (@(posedge clk) disable iff (rst)
    (done && $past(kind == KIND_POINT, LATENCY)) |-> (verdict != VERDICT_MID))
    else $error("point classified as intermediate");

  // An invalid box is always intermediate
  a_invalid_box: assert property (@(posedge clk) disable iff (rst)
    (done && $past(kind == KIND_BOX && !box_valid, LATENCY)) |->
      (verdict == VERDICT_MID))
    else $error("invalid box not intermediate");

endmodule

bind plane_set_cull_test_top psct_checker u_psct_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .box_valid (box_valid),
  .done      (done),
  .verdict   (verdict)
);
